// ===== rtl/core/int64_to_decimal_ascii_top_assert.svh =====
// Assertion macros for the decimal text converter.
// Used by the top level; needs i_clk and i_rst_n in scope.
`ifndef INT64_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define INT64_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define I2DA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("i2da: implication check failed");

// Next-cycle implication, checked out of reset.
`define I2DA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("i2da: next-cycle check failed");

`endif

// ===== rtl/core/i2da_pkg.sv =====
// Shared types and constants for the decimal text converter.
// No dependencies.
package i2da_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int IN_DATA_W       = 64;
    localparam int OUT_DATA_W      = 8;
    localparam int CHAR_W          = 6;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

    localparam logic [3:0] BCD_THRESH = 4'd5;
    localparam logic [3:0] BCD_BIAS   = 4'd3;
    localparam logic [3:0] BCD_MAX    = 4'd9;

    // Operation applied to every digit cell in a cycle
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_DABBLE = 2'd2,
        OP_SHIFT  = 2'd3
    } t_cell_op;

endpackage

// ===== rtl/core/int64_to_decimal_ascii_top.sv =====
// Integer to decimal ASCII converter, top level.
// Depends on i2da_pkg, i2da_cell and int64_to_decimal_ascii_top_assert.svh.
//
// Usage:
//   Input channel (i_s_*): one word per number. tdata carries the raw value,
//   of which the low VALUE_WIDTH bits count; tuser bit 0 selects a signed
//   (two's complement) reading.
//   Output channel (o_m_*): one ASCII character per word, most significant
//   first, '-' ahead of negative values; tlast marks the final digit.
// Timing:
//   A number is taken only while the converter is idle. The value is shifted
//   bit by bit into a chain of BCD cells. Leading zero digits are then
//   shifted out at one per cycle, the leading digit is found, and each
//   character leaves at one per cycle while the output is not stalled.
// Reset: synchronous, active low; clears the controller and output valid.
// Stall: a held output character stops the chain; no character is lost.
//   The next number is accepted while the final character still waits.
`include "int64_to_decimal_ascii_top_assert.svh"

module int64_to_decimal_ascii_top
    import i2da_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [63:0] value_bits
    input  logic                  i_s_tuser,   // [0] is_signed
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [5:0] text_char, [7:6] zero
    output logic                  o_m_tlast    // is_last
);

    // decimal digits of 2^VALUE_WIDTH - 1
    localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int CW   = $clog2(VALUE_WIDTH + 1);
    localparam int LW   = $clog2(NDIG + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_CONV = 2'd1,
        ST_SKIP = 2'd2,
        ST_EMIT = 2'd3
    } t_state;

    t_state                  r_state;
    logic [VALUE_WIDTH-1:0]  r_mag;
    logic                    r_neg;
    logic [CW-1:0]           r_cnt;
    logic [LW-1:0]           r_left;
    logic                    r_m_valid;
    logic [CHAR_W-1:0]       r_m_char;
    logic                    r_m_last;

    logic [VALUE_WIDTH-1:0]  c_raw;
    logic                    c_neg;
    logic [VALUE_WIDTH-1:0]  c_mag;
    logic                    c_accept;
    logic                    c_load;
    logic                    c_top_zero;
    t_cell_op                c_op;

    logic [3:0]              w_digit [NDIG];
    logic                    w_carry [NDIG];

    assign c_raw      = i_s_tdata[VALUE_WIDTH-1:0];
    assign c_neg      = i_s_tuser & c_raw[VALUE_WIDTH-1];
    assign c_mag      = c_neg ? (VALUE_WIDTH'(0) - c_raw) : c_raw;
    assign o_s_tready = (r_state == ST_IDLE);
    assign c_accept   = i_s_tvalid & o_s_tready;
    assign c_load     = (r_state == ST_EMIT) & (~r_m_valid | i_m_tready);
    assign c_top_zero = (w_digit[NDIG-1] == 4'd0);

    always_comb begin
        case (r_state)
            ST_IDLE: c_op = c_accept ? OP_CLEAR : OP_HOLD;
            ST_CONV: c_op = OP_DABBLE;
            ST_SKIP: c_op = (c_top_zero && (r_left > LW'(1))) ? OP_SHIFT : OP_HOLD;
            ST_EMIT: c_op = (c_load && !r_neg) ? OP_SHIFT : OP_HOLD;
            default: c_op = OP_HOLD;
        endcase
    end

    // digit chain: cell 0 is the units digit, the top cell the leading one
    for (genvar g = 0; g < NDIG; g++) begin : g_cell
        logic       w_bit_in;
        logic [3:0] w_dig_in;
        if (g == 0) begin : g_first
            assign w_bit_in = r_mag[VALUE_WIDTH-1];
            assign w_dig_in = 4'd0;
        end else begin : g_rest
            assign w_bit_in = w_carry[g-1];
            assign w_dig_in = w_digit[g-1];
        end
        i2da_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (c_op),
            .i_bit   (w_bit_in),
            .i_digit (w_dig_in),
            .o_digit (w_digit[g]),
            .o_carry (w_carry[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_neg     <= 1'b0;
            r_cnt     <= '0;
            r_left    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (c_accept) begin
                        r_neg   <= c_neg;
                        r_cnt   <= CW'(VALUE_WIDTH);
                        r_state <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_left  <= LW'(NDIG);
                        r_state <= ST_SKIP;
                    end
                end
                ST_SKIP: begin
                    // drop leading zeros, keep at least one digit
                    if (!c_top_zero || (r_left == LW'(1))) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_left <= r_left - LW'(1);
                    end
                end
                ST_EMIT: begin
                    if (c_load) begin
                        if (r_neg) begin
                            r_neg <= 1'b0;
                        end else begin
                            r_left <= r_left - LW'(1);
                            if (r_left == LW'(1)) begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (c_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // magnitude shift register and output word payload
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_mag <= c_mag;
        end else if (r_state == ST_CONV) begin
            r_mag <= {r_mag[VALUE_WIDTH-2:0], 1'b0};
        end
        if (c_load) begin
            if (r_neg) begin
                r_m_char <= CH_MINUS;
                r_m_last <= 1'b0;
            end else begin
                r_m_char <= CH_ZERO + {2'b00, w_digit[NDIG-1]};
                r_m_last <= (r_left == LW'(1));
            end
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(OUT_DATA_W-CHAR_W){1'b0}}, r_m_char};
    assign o_m_tlast  = r_m_last;

    `I2DA_ASSERT_IMP(a_no_top_overflow, r_state == ST_CONV, !w_carry[NDIG-1])
    `I2DA_ASSERT_IMP(a_top_is_bcd, r_state == ST_EMIT, w_digit[NDIG-1] <= BCD_MAX)
    `I2DA_ASSERT_IMP(a_digits_left, r_state == ST_EMIT || r_state == ST_SKIP, r_left != '0)
    `I2DA_ASSERT_NXT(a_accept_to_conv, c_accept, r_state == ST_CONV && r_cnt == CW'(VALUE_WIDTH))
    `I2DA_ASSERT_IMP(a_last_not_sign, o_m_tvalid && o_m_tlast, r_m_char != CH_MINUS)

endmodule

// ===== rtl/core/i2da_cell.sv =====
// One BCD digit cell of the shift-add-3 chain.
// Depends on i2da_pkg for the cell operation type.
module i2da_cell
    import i2da_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_op   i_op,
    input  logic       i_bit,     // carry bit from the lower cell
    input  logic [3:0] i_digit,   // digit of the lower cell
    output logic [3:0] o_digit,
    output logic       o_carry
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] c_adj;

    always_comb begin
        // add 3 ahead of the doubling so the digit wraps into the next cell
        c_adj = (r_digit >= BCD_THRESH) ? (r_digit + BCD_BIAS) : r_digit;
        case (i_op)
            OP_CLEAR:  n_digit = 4'd0;
            OP_DABBLE: n_digit = {c_adj[2:0], i_bit};
            OP_SHIFT:  n_digit = i_digit;
            OP_HOLD:   n_digit = r_digit;
            default:   n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_digit = r_digit;
    assign o_carry = c_adj[3];

endmodule
